// File: hw/rtl/rbp_pkg.sv
// Shared types, codes and word helpers for the range bitmap unit.
package rbp_pkg;

   localparam int MAX_OBJECTS_DEF = 65536;
   localparam int POS_W           = 16;
   localparam int CNT_W           = 17;
   localparam int CMD_W           = 3;
   localparam int WIDX_W          = POS_W - 5;
   localparam int BIT_W           = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_FILL  = 3'd0,
      CMD_SET   = 3'd1,
      CMD_CLEAR = 3'd2,
      CMD_COUNT = 3'd3,
      CMD_EMPTY = 3'd4,
      CMD_FULL  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] range_first;
      logic [POS_W-1:0] range_last;
      logic             fill_value;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] ones_count;
      logic             answer_flag;
      logic             range_error;
   } rsp_type;

   // word unit control: where the word sits and what to do to it
   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [WIDX_W-1:0] word_idx;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  last;
   } alu_ctl_type;

   typedef struct packed {
      logic [31:0]      new_word;
      logic [BIT_W-1:0] hit_count;
      logic [BIT_W-1:0] mask_count;
      logic             all_zero;
      logic             all_one;
   } alu_res_type;

   function automatic logic [BIT_W-1:0] popcount32(input logic [31:0] v);
      logic [BIT_W-1:0] c;
      c = '0;
      for (int i = 0; i < 32; i++) begin
         c = c + BIT_W'(v[i]);
      end
      return c;
   endfunction

   // word contents after a fill of cnt positions; w is the word index
   function automatic logic [31:0] fill_word(input logic [CNT_W-6:0] w,
                                             input logic [CNT_W-1:0] cnt);
      logic [31:0] r;
      if (w < cnt[CNT_W-1:5]) begin
         r = 32'hFFFF_FFFF;
      end else if (w == cnt[CNT_W-1:5]) begin
         r = ~(32'hFFFF_FFFF << cnt[4:0]);
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/rbp_mem.sv
// Bitmap word store: one write port, one registered read port.
module rbp_mem #(
   parameter int WORDS = 2048,
   parameter int WAW   = 11
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [WAW-1:0] wr_addr,
   input  logic [31:0]    wr_data,
   input  logic           rd_en,
   input  logic [WAW-1:0] rd_addr,
   output logic [31:0]    rd_data_ff
);

   logic [31:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/rbp_word_alu.sv
// Per-word range unit: mask, masked popcount, tests and updated word.
module rbp_word_alu (
   input  rbp_pkg::alu_ctl_type ctl,
   input  logic [31:0]          old_word,
   output rbp_pkg::alu_res_type res
);
   import rbp_pkg::*;

   logic [4:0]  lo;
   logic [4:0]  hi;
   logic [31:0] mask;
   logic [31:0] masked;

   always_comb begin
      lo     = (ctl.word_idx == ctl.first[POS_W-1:5]) ? ctl.first[4:0] : 5'd0;
      hi     = (ctl.word_idx == ctl.last[POS_W-1:5]) ? ctl.last[4:0] : 5'd31;
      mask   = (32'hFFFF_FFFF >> (5'd31 - hi)) & (32'hFFFF_FFFF << lo);
      masked = old_word & mask;

      res.hit_count  = popcount32(masked);
      res.mask_count = BIT_W'({1'b0, hi}) - BIT_W'({1'b0, lo}) + BIT_W'(1);
      res.all_zero   = (masked == '0);
      res.all_one    = (masked == mask);

      case (ctl.op)
         CMD_SET:   res.new_word = old_word | mask;
         CMD_CLEAR: res.new_word = old_word & ~mask;
         default:   res.new_word = old_word;
      endcase
   end

endmodule

// File: hw/rtl/range_bitmap_with_popcount_unit.sv
// Range bitmap with popcount: sequencer, running total and result logic.
// Range commands: each spanned word is read and folded in, then a flush step, then the result strobe.
// Fill/clear all: one word written per cycle across the whole store, then the result strobe.
// Bad range or unknown command: strobe in the cycle after accept. One command at a time.
// Reset and every csr write clear the store in a pass over all WORDS words (2048 by default), busy high.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.
module range_bitmap_with_popcount_unit #(
   parameter int MAX_OBJECTS = rbp_pkg::MAX_OBJECTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rbp_pkg::req_type            req_word,
   output logic                        rsp_valid,
   output rbp_pkg::rsp_type            rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rbp_pkg::CNT_W-1:0]   csr_data
);
   import rbp_pkg::*;

   localparam int WORDS = (MAX_OBJECTS + 31) / 32;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SWEEP = 5'b00010,
      S_WALK  = 5'b00100,
      S_FLUSH = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] obj_count_ff, obj_count_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] ones_ff, ones_in;
   logic             all_zero_ff, all_zero_in;
   logic             all_one_ff, all_one_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [POS_W-1:0] first_ff, first_in;
   logic [POS_W-1:0] last_ff, last_in;
   logic             fill_ff, fill_in;
   logic             err_ff, err_in;
   logic             reply_ff, reply_in;
   logic [WAW-1:0]   addr_ff, addr_in;
   logic [WAW-1:0]   proc_addr_ff, proc_addr_in;
   logic             proc_valid_ff, proc_valid_in;

   logic [CNT_W-1:0] cnt;
   logic             bad_range;
   logic [WAW-1:0]   last_w;
   logic             wr_en;
   logic [WAW-1:0]   wr_addr;
   logic [31:0]      wr_data;
   logic             rd_en;
   logic [31:0]      rd_data_ff;
   alu_ctl_type      alu_ctl;
   alu_res_type      alu_res;

   // effective count: zero acts as one, clamp at the map size
   always_comb begin
      if (obj_count_ff == '0) begin
         cnt = CNT_W'(1);
      end else if (obj_count_ff > CNT_W'(MAX_OBJECTS)) begin
         cnt = CNT_W'(MAX_OBJECTS);
      end else begin
         cnt = obj_count_ff;
      end
   end

   assign bad_range = (req_word.range_first > req_word.range_last) ||
                      ({1'b0, req_word.range_last} >= cnt);
   assign last_w    = WAW'(last_ff[POS_W-1:5]);

   assign alu_ctl.op       = cmd_ff;
   assign alu_ctl.word_idx = WIDX_W'(proc_addr_ff);
   assign alu_ctl.first    = first_ff;
   assign alu_ctl.last     = last_ff;

   rbp_word_alu u_alu (
      .ctl      (alu_ctl),
      .old_word (rd_data_ff),
      .res      (alu_res)
   );

   rbp_mem #(
      .WORDS (WORDS),
      .WAW   (WAW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .rd_data_ff (rd_data_ff)
   );

   always_comb begin
      rd_en = (state_ff == S_WALK);
      if (state_ff == S_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = addr_ff;
         wr_data = fill_ff ? fill_word((CNT_W-5)'(addr_ff), cnt) : 32'h0;
      end else begin
         wr_en   = proc_valid_ff && ((cmd_ff == CMD_SET) || (cmd_ff == CMD_CLEAR));
         wr_addr = proc_addr_ff;
         wr_data = alu_res.new_word;
      end
   end

   always_comb begin
      state_in      = state_ff;
      obj_count_in  = obj_count_ff;
      total_in      = total_ff;
      ones_in       = ones_ff;
      all_zero_in   = all_zero_ff;
      all_one_in    = all_one_ff;
      cmd_in        = cmd_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      fill_in       = fill_ff;
      err_in        = err_ff;
      reply_in      = reply_ff;
      addr_in       = addr_ff;
      proc_addr_in  = proc_addr_ff;
      proc_valid_in = 1'b0;

      // fold in the word read last cycle
      if (proc_valid_ff) begin
         ones_in     = ones_ff + CNT_W'(alu_res.hit_count);
         all_zero_in = all_zero_ff & alu_res.all_zero;
         all_one_in  = all_one_ff & alu_res.all_one;
         if (cmd_ff == CMD_SET) begin
            total_in = total_ff + CNT_W'(alu_res.mask_count) - CNT_W'(alu_res.hit_count);
         end else if (cmd_ff == CMD_CLEAR) begin
            total_in = total_ff - CNT_W'(alu_res.hit_count);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_word.command;
               first_in    = req_word.range_first;
               last_in     = req_word.range_last;
               fill_in     = req_word.fill_value;
               ones_in     = '0;
               all_zero_in = 1'b1;
               all_one_in  = 1'b1;
               err_in      = 1'b0;
               if (req_word.command == CMD_FILL) begin
                  total_in = req_word.fill_value ? cnt : '0;
                  addr_in  = '0;
                  reply_in = 1'b1;
                  state_in = S_SWEEP;
               end else if (req_word.command > CMD_FULL) begin
                  state_in = S_DONE;
               end else if (bad_range) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  addr_in  = WAW'(req_word.range_first[POS_W-1:5]);
                  state_in = S_WALK;
               end
            end
         end
         S_SWEEP: begin
            addr_in = addr_ff + WAW'(1);
            if (addr_ff == WAW'(WORDS - 1)) begin
               state_in = reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_WALK: begin
            proc_valid_in = 1'b1;
            proc_addr_in  = addr_ff;
            addr_in       = addr_ff + WAW'(1);
            if (addr_ff == last_w) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a count write wipes the map
      if (csr_valid && csr_ready) begin
         obj_count_in  = csr_data;
         total_in      = '0;
         fill_in       = 1'b0;
         reply_in      = 1'b0;
         addr_in       = '0;
         proc_valid_in = 1'b0;
         state_in      = S_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         obj_count_ff  <= CNT_W'(32'h10000);
         total_ff      <= '0;
         fill_ff       <= 1'b0;
         reply_ff      <= 1'b0;
         addr_ff       <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         obj_count_ff  <= obj_count_in;
         total_ff      <= total_in;
         fill_ff       <= fill_in;
         reply_ff      <= reply_in;
         addr_ff       <= addr_in;
         proc_valid_ff <= proc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ones_ff      <= ones_in;
      all_zero_ff  <= all_zero_in;
      all_one_ff   <= all_one_in;
      cmd_ff       <= cmd_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
      proc_addr_ff <= proc_addr_in;
   end

   assign busy      = (state_ff != S_IDLE);
   // count writes only between commands, never alongside a new one
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      rsp_word.range_error = err_ff;
      rsp_word.ones_count  = total_ff;
      rsp_word.answer_flag = 1'b0;
      if (!err_ff) begin
         case (cmd_ff)
            CMD_FILL:  rsp_word.answer_flag = 1'b1;
            CMD_SET:   rsp_word.answer_flag = (total_ff == cnt);
            CMD_CLEAR: rsp_word.answer_flag = (total_ff == '0);
            CMD_COUNT: rsp_word.ones_count  = ones_ff;
            CMD_EMPTY: rsp_word.answer_flag = all_zero_ff;
            CMD_FULL:  rsp_word.answer_flag = all_one_ff;
            default:   rsp_word.answer_flag = 1'b0;
         endcase
      end
   end

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted command left block idle");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_err_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.range_error) |-> !rsp_word.answer_flag)
      else $error("flag set on bad range");

endmodule
